FILE: src/rdt_pkg.sv
// package for the running drawdown tracker: shared constants, state enums
// and the divider status struct; no dependencies
package rdt_pkg;

  // percent result width and fraction bits of all fixed point values
  localparam int unsigned PCT_W   = 32;
  localparam int unsigned FRAC_W  = 16;
  // depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [PCT_W-1:0] PCT_MAX = {1'b0, {(PCT_W-1){1'b1}}};
  localparam logic [PCT_W-1:0] PCT_MIN = {1'b1, {(PCT_W-1){1'b0}}};

  // back end sequencer
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_PREP,
    BK_START,
    BK_WAIT,
    BK_POST,
    BK_OUT
  } back_state_e;

  // divider sequencer
  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_CHECK,
    DIV_STEP
  } div_state_e;

  // divider status toward the back end
  typedef struct packed {
    logic done;  // one-cycle pulse, quotient valid
    logic ovf;   // quotient does not fit in PCT_W bits
  } div_status_t;

endpackage

FILE: src/rdt_front.sv
// front end: mode register, value select, running peak and drawdown classify
// depends on rdt_pkg
module rdt_front import rdt_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 48
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [VALUE_WIDTH-1:0] portfolio_value_i,
  input  logic signed [VALUE_WIDTH-1:0] fund_value_i,
  input  logic                          full_i,
  output logic                          push_o,
  output logic [2*VALUE_WIDTH:0]        push_data_o
);

  logic                   fund_mode_q;
  logic [VALUE_WIDTH-1:0] peak_q, peak_d;
  logic [VALUE_WIDTH-1:0] cur_value;
  logic [VALUE_WIDTH:0]   gap;
  logic                   rise;
  logic [VALUE_WIDTH-1:0] diff;
  logic                   no_pct;

  // mode register, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fund_mode_q <= 1'b0;
    end else if (cfg_valid_i) begin
      fund_mode_q <= cfg_data_i;
    end
  end

  // current value and signed gap to the old peak, sign bit says a new peak
  assign cur_value = fund_mode_q ? fund_value_i : portfolio_value_i;
  assign gap  = {peak_q[VALUE_WIDTH-1], peak_q} - {cur_value[VALUE_WIDTH-1], cur_value};
  assign rise = gap[VALUE_WIDTH];

  assign peak_d = rise ? cur_value : peak_q;
  assign diff   = rise ? '0 : gap[VALUE_WIDTH-1:0];
  // zero drawdown or zero peak skips the divide
  assign no_pct = rise || (peak_q == '0) || (gap == '0);

  assign in_ready_o  = !full_i;
  assign push_o      = in_valid_i && !full_i;
  assign push_data_o = {no_pct, peak_d, diff};

  // running peak, starts at the most negative value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q <= {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    end else if (push_o) begin
      peak_q <= peak_d;
    end
  end

endmodule

FILE: src/rdt_queue.sv
// small register queue between front and back end
// depends on rdt_pkg (no items used beyond the import convention)
module rdt_queue import rdt_pkg::*; #(
  parameter int unsigned WIDTH = 97,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  assign full_o     = (count_q == CNT_W'(DEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = entry_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  // no overrun or underrun from the neighbors
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("queue push while full");
  a_no_underrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("queue pop while empty");
`endif

endmodule

FILE: src/rdt_div.sv
// restoring divider, one quotient bit per cycle, with overflow check
// depends on rdt_pkg (PCT_W, div_state_e, div_status_t)
module rdt_div import rdt_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 48
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [VALUE_WIDTH-1:0] num_hi_i,
  input  logic [PCT_W-1:0]       num_lo_i,
  input  logic [VALUE_WIDTH-1:0] den_i,
  output div_status_t            status_o,
  output logic [PCT_W-1:0]       quo_o
);

  localparam int unsigned CNT_W = $clog2(PCT_W);

  div_state_e             state_q, state_d;
  logic [VALUE_WIDTH-1:0] rem_q, den_q;
  logic [PCT_W-1:0]       shift_q;
  logic [CNT_W-1:0]       cnt_q;
  logic                   done_q, ovf_q;
  logic                   done_d, ovf_d;
  logic [VALUE_WIDTH-1:0] rem_shift;
  logic                   take;
  logic                   last;

  // remainder stays below the divisor, so the top bit is free for the shift
  assign rem_shift = {rem_q[VALUE_WIDTH-2:0], shift_q[PCT_W-1]};
  assign take      = (rem_shift >= den_q);
  assign last      = (cnt_q == CNT_W'(PCT_W-1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
      done_q  <= 1'b0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      ovf_q   <= ovf_d;
    end
  end

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    ovf_d   = ovf_q;
    unique case (state_q)
      DIV_IDLE: begin
        if (start_i) begin
          state_d = DIV_CHECK;
        end
      end
      DIV_CHECK: begin
        // high half not below divisor means quotient needs more than PCT_W bits
        if (rem_q >= den_q) begin
          ovf_d   = 1'b1;
          done_d  = 1'b1;
          state_d = DIV_IDLE;
        end else begin
          ovf_d   = 1'b0;
          state_d = DIV_STEP;
        end
      end
      DIV_STEP: begin
        if (last) begin
          done_d  = 1'b1;
          state_d = DIV_IDLE;
        end
      end
      default: state_d = DIV_IDLE;
    endcase
  end

  // datapath: remainder, dividend low bits shifting out, quotient shifting in
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      DIV_IDLE: begin
        if (start_i) begin
          rem_q   <= num_hi_i;
          shift_q <= num_lo_i;
          den_q   <= den_i;
        end
      end
      DIV_CHECK: begin
        cnt_q <= '0;
      end
      DIV_STEP: begin
        rem_q   <= take ? rem_shift - den_q : rem_shift;
        shift_q <= {shift_q[PCT_W-2:0], take};
        cnt_q   <= cnt_q + 1'b1;
      end
      default: begin
        cnt_q <= '0;
      end
    endcase
  end

  assign status_o.done = done_q;
  assign status_o.ovf  = ovf_q;
  assign quo_o         = shift_q;

`ifndef ASSERT_OFF
  // result pulse only once the sequencer is back at rest
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == DIV_IDLE) else $error("divider done while busy");
`endif

endmodule

FILE: src/rdt_back.sv
// back end: percent divide, running maxima, run counters, output register
// depends on rdt_pkg and rdt_div
module rdt_back import rdt_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 48,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          empty_i,
  input  logic [2*VALUE_WIDTH:0]        pop_data_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [VALUE_WIDTH-1:0] money_down_o,
  output logic signed [PCT_W-1:0]       percent_down_o,
  output logic [VALUE_WIDTH-2:0]        max_money_down_o,
  output logic [PCT_W-2:0]              max_percent_down_o,
  output logic [COUNT_WIDTH-1:0]        down_run_length_o,
  output logic [COUNT_WIDTH-1:0]        max_down_run_length_o
);

  // diff*100 needs 7 more bits
  localparam int unsigned PROD_W = VALUE_WIDTH + 7;
  localparam int unsigned HI_W   = PROD_W - FRAC_W;

  back_state_e            state_q, state_d;
  logic                   no_pct_q;
  logic [VALUE_WIDTH-1:0] peak_q, diff_q;
  logic [PROD_W-1:0]      prod_q;
  logic [VALUE_WIDTH-1:0] den_q;
  logic [PCT_W-1:0]       pct_q, pct_d;
  logic                   div_start;
  div_status_t            div_status;
  logic [PCT_W-1:0]       quo;
  logic [PROD_W-1:0]      diff_ext;
  logic                   load;
  logic                   sat;
  logic [VALUE_WIDTH-2:0] money;
  logic                   pct_pos;
  logic                   run_full;

  logic                   out_valid_q;
  logic [VALUE_WIDTH-1:0] money_out_q;
  logic [PCT_W-1:0]       pct_out_q;
  logic [VALUE_WIDTH-2:0] max_money_q;
  logic [PCT_W-2:0]       max_pct_q;
  logic [COUNT_WIDTH-1:0] run_q, longest_q;

  rdt_div #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_hi_i({{(VALUE_WIDTH-HI_W){1'b0}}, prod_q[PROD_W-1:FRAC_W]}),
    .num_lo_i({prod_q[FRAC_W-1:0], {(PCT_W-FRAC_W){1'b0}}}),
    .den_i   (den_q),
    .status_o(div_status),
    .quo_o   (quo)
  );

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    pop_o     = 1'b0;
    div_start = 1'b0;
    load      = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          state_d = BK_PREP;
        end
      end
      BK_PREP:  state_d = no_pct_q ? BK_POST : BK_START;
      BK_START: begin
        div_start = 1'b1;
        state_d   = BK_WAIT;
      end
      BK_WAIT: begin
        if (div_status.done) begin
          state_d = BK_POST;
        end
      end
      BK_POST:  state_d = BK_OUT;
      BK_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          load    = 1'b1;
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // diff*6553600 = (diff*100) << 16, the times hundred as shifts and adds
  assign diff_ext = {{(PROD_W-VALUE_WIDTH){1'b0}}, diff_q};

  // signed percent from quotient, saturated, sign of the peak
  assign sat = div_status.ovf || quo[PCT_W-1];
  always_comb begin
    if (no_pct_q) begin
      pct_d = '0;
    end else if (peak_q[VALUE_WIDTH-1]) begin
      pct_d = sat ? PCT_MIN : (~quo + 1'b1);
    end else begin
      pct_d = sat ? PCT_MAX : quo;
    end
  end

  // item datapath
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      {no_pct_q, peak_q, diff_q} <= pop_data_i;
    end
    if (state_q == BK_PREP) begin
      prod_q <= (diff_ext << 6) + (diff_ext << 5) + (diff_ext << 2);
      den_q  <= peak_q[VALUE_WIDTH-1] ? (~peak_q + 1'b1) : peak_q;
    end
    if (state_q == BK_POST) begin
      pct_q <= pct_d;
    end
  end

  // money saturates at the largest positive value
  assign money    = diff_q[VALUE_WIDTH-1] ? '1 : diff_q[VALUE_WIDTH-2:0];
  assign pct_pos  = !pct_q[PCT_W-1] && (pct_q != '0);
  assign run_full = (run_q == '1);

  always_ff @(posedge clk_i) begin
    if (load) begin
      money_out_q <= {1'b0, money};
      pct_out_q   <= pct_q;
    end
  end

  // running statistics and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      max_money_q <= '0;
      max_pct_q   <= '0;
      run_q       <= '0;
      longest_q   <= '0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (load) begin
        if (money > max_money_q) begin
          max_money_q <= money;
        end
        if (!pct_q[PCT_W-1] && (pct_q[PCT_W-2:0] > max_pct_q)) begin
          max_pct_q <= pct_q[PCT_W-2:0];
        end
        // longest never trails the run, so it only moves when they match
        if (!pct_pos) begin
          run_q <= '0;
        end else if (!run_full) begin
          run_q <= run_q + 1'b1;
          if (run_q == longest_q) begin
            longest_q <= run_q + 1'b1;
          end
        end
      end
    end
  end

  assign out_valid_o           = out_valid_q;
  assign money_down_o          = money_out_q;
  assign percent_down_o        = pct_out_q;
  assign max_money_down_o      = max_money_q;
  assign max_percent_down_o    = max_pct_q;
  assign down_run_length_o     = run_q;
  assign max_down_run_length_o = longest_q;

`ifndef ASSERT_OFF
  // current run never exceeds the longest run
  a_run_le_longest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q <= longest_q) else $error("run length above longest run");
  // largest money drawdown only grows
  a_max_money_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> max_money_q >= $past(max_money_q))
    else $error("max money drawdown decreased");
  // statistics hold while a result waits
  a_stats_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> $stable(run_q) && $stable(max_pct_q))
    else $error("statistics changed under a stalled beat");
`endif

endmodule

FILE: src/running_drawdown_tracker_core.sv
// Running drawdown tracker, top level.
// Channels: input beats (portfolio_value_i, fund_value_i) on in_valid_i/in_ready_o,
// result beats on out_valid_o/out_ready_i, and a one-bit mode write channel
// (cfg_valid_i/cfg_ready_o/cfg_data_i, 0 portfolio, 1 fund, always ready).
// Each input beat gives exactly one result beat, in order.
// The front end picks the value, updates the peak and queues the item in a
// two-entry queue; the back end runs a restoring divider, one quotient bit
// per cycle, for the percent drawdown.
// The back end handles one item at a time, through prepare, divider start, wait,
// post and output steps; the 32 divider steps are skipped, with start and wait,
// when the drawdown or the peak is zero. It pops the next item only once the
// last result is loaded into the output register.
// The front takes up to two more items while the back end is busy.
// Reset: peak goes to the most negative value, maxima and run counts to zero,
// mode to portfolio, no result pending.
// Receiver stall: the result holds in the output register; the back end
// waits, and the front stops taking items once the queue is full.
// Depends on rdt_pkg, rdt_front, rdt_queue, rdt_back.
module running_drawdown_tracker_core import rdt_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 48,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [VALUE_WIDTH-1:0] portfolio_value_i,
  input  logic signed [VALUE_WIDTH-1:0] fund_value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [VALUE_WIDTH-1:0] money_down_o,
  output logic signed [PCT_W-1:0]       percent_down_o,
  output logic [VALUE_WIDTH-2:0]        max_money_down_o,
  output logic [PCT_W-2:0]              max_percent_down_o,
  output logic [COUNT_WIDTH-1:0]        down_run_length_o,
  output logic [COUNT_WIDTH-1:0]        max_down_run_length_o
);

  localparam int unsigned ENTRY_W = 2 * VALUE_WIDTH + 1;

  logic               push, pop, full, empty;
  logic [ENTRY_W-1:0] push_data, pop_data;

  rdt_front #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .portfolio_value_i(portfolio_value_i),
    .fund_value_i     (fund_value_i),
    .full_i           (full),
    .push_o           (push),
    .push_data_o      (push_data)
  );

  rdt_queue #(
    .WIDTH(ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .pop_i      (pop),
    .pop_data_o (pop_data),
    .full_o     (full),
    .empty_o    (empty)
  );

  rdt_back #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .empty_i              (empty),
    .pop_data_i           (pop_data),
    .pop_o                (pop),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .money_down_o         (money_down_o),
    .percent_down_o       (percent_down_o),
    .max_money_down_o     (max_money_down_o),
    .max_percent_down_o   (max_percent_down_o),
    .down_run_length_o    (down_run_length_o),
    .max_down_run_length_o(max_down_run_length_o)
  );

endmodule

FILE: verif/drawdown_checker.sv
// result checker for the running drawdown tracker: watches the mode, input and
// result channels, predicts every result beat and compares it field by field
// depends on rdt_pkg for the percent width and its saturation limits
module drawdown_checker
  import rdt_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 48,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic                          cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic signed [VALUE_WIDTH-1:0] portfolio_value_i,
  input  logic signed [VALUE_WIDTH-1:0] fund_value_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [VALUE_WIDTH-1:0]        money_down_i,
  input  logic [PCT_W-1:0]              percent_down_i,
  input  logic [VALUE_WIDTH-2:0]        max_money_down_i,
  input  logic [PCT_W-2:0]              max_percent_down_i,
  input  logic [COUNT_WIDTH-1:0]        down_run_length_i,
  input  logic [COUNT_WIDTH-1:0]        max_down_run_length_i,
  output int                            pending_beats_o,
  output int                            errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // 100 percent in 16 fraction bits
  localparam logic [127:0] PERCENT_SCALE = 128'd6553600;
  localparam logic [63:0]  MONEY_LIMIT   = (64'd1 << (VALUE_WIDTH - 1)) - 64'd1;
  localparam logic signed [63:0] PEAK_RESET = -(64'sd1 <<< (VALUE_WIDTH - 1));

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] money;
    logic [PCT_W-1:0]       pct;
    logic [VALUE_WIDTH-2:0] max_money;
    logic [PCT_W-2:0]       max_pct;
    logic [COUNT_WIDTH-1:0] run;
    logic [COUNT_WIDTH-1:0] longest;
  } drawdown_t;

  // shadow of the tracker state
  logic                    fund_mode;
  logic signed [63:0]      peak;
  logic [63:0]             top_money;
  logic signed [PCT_W-1:0] top_pct;
  logic [COUNT_WIDTH-1:0]  run_len;
  logic [COUNT_WIDTH-1:0]  longest_run;

  drawdown_t expected_q[$];
  int        mismatch_count = 0;
  int        beat_count = 0;

  assign errors_o = mismatch_count;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string field, input logic [63:0] seen,
                             input logic [63:0] want);
    if (seen !== want)
      report_mismatch($sformatf("beat %0d %s: got %0h, expected %0h",
                                beat_count, field, seen, want));
  endtask

  // one drawdown update: raise the peak, then money, percent, maxima and runs
  function automatic drawdown_t predict_drawdown(input logic signed [VALUE_WIDTH-1:0] value);
    logic signed [63:0]      v;
    logic [63:0]             diff;
    logic [63:0]             money;
    logic [63:0]             mag;
    logic [127:0]            quot;
    logic signed [PCT_W-1:0] pct;
    drawdown_t               res;
    v = value;
    if (v > peak) peak = v;
    diff  = peak - v;
    money = (diff > MONEY_LIMIT) ? MONEY_LIMIT : diff;

    // percent takes the exact difference over the peak magnitude, sign of the peak
    if (peak == 0 || diff == 0) begin
      pct = '0;
    end else begin
      mag  = (peak < 0) ? -peak : peak;
      quot = ({64'd0, diff} * PERCENT_SCALE) / {64'd0, mag};
      if (peak < 0) begin
        if (quot >= 128'h8000_0000) pct = PCT_MIN;
        else pct = PCT_W'(0) - quot[PCT_W-1:0];
      end else begin
        if (quot > 128'(PCT_MAX)) pct = PCT_MAX;
        else pct = quot[PCT_W-1:0];
      end
    end

    if (money > top_money) top_money = money;
    if (pct > top_pct) top_pct = pct;

    // runs count only strictly positive percent, saturating
    if (pct > 0) begin
      if (run_len != '1) run_len++;
    end else begin
      run_len = '0;
    end
    if (run_len > longest_run) longest_run = run_len;

    res.money     = money[VALUE_WIDTH-1:0];
    res.pct       = pct;
    res.max_money = top_money[VALUE_WIDTH-2:0];
    res.max_pct   = top_pct[PCT_W-2:0];
    res.run       = run_len;
    res.longest   = longest_run;
    return res;
  endfunction

  // results first, so a beat leaving never pairs with one entering this edge
  always @(posedge clk_i or negedge rst_ni) begin
    drawdown_t want;
    if (!rst_ni) begin
      fund_mode   = 1'b0;
      peak        = PEAK_RESET;
      top_money   = '0;
      top_pct     = '0;
      run_len     = '0;
      longest_run = '0;
      expected_q.delete();
      pending_beats_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        beat_count++;
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("result beat %0d arrived with nothing pending",
                                    beat_count));
        end else begin
          want = expected_q.pop_front();
          check_field("money_down", money_down_i, want.money);
          check_field("percent_down", percent_down_i, want.pct);
          check_field("max_money_down", max_money_down_i, want.max_money);
          check_field("max_percent_down", max_percent_down_i, want.max_pct);
          check_field("down_run_length", down_run_length_i, want.run);
          check_field("max_down_run_length", max_down_run_length_i, want.longest);
        end
      end
      if (cfg_valid_i && cfg_ready_i) fund_mode = cfg_data_i;
      if (in_valid_i && in_ready_i)
        expected_q.push_back(predict_drawdown(fund_mode ? fund_value_i : portfolio_value_i));
      pending_beats_o <= expected_q.size();
    end
  end

endmodule

FILE: verif/running_drawdown_tracker_core_test.sv
// top of the running drawdown tracker testbench: clock, reset, stimulus,
// receiver stalls, watchdog and verdict
// depends on rdt_pkg, running_drawdown_tracker_core and drawdown_checker
module running_drawdown_tracker_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import rdt_pkg::*;

  localparam int unsigned VALUE_WIDTH   = 48;
  localparam int unsigned COUNT_WIDTH   = 32;
  localparam longint      VALUE_MIN     = -(longint'(1) <<< (VALUE_WIDTH - 1));
  localparam longint      VALUE_MAX     = (longint'(1) <<< (VALUE_WIDTH - 1)) - 1;
  localparam longint      NEG_PEAK      = -(longint'(1) <<< 32);
  localparam longint      HALF_STEP     = longint'(1) <<< 31;
  localparam int          RESET_CYCLES  = 11;
  localparam int          DRAIN_CYCLES  = 60;
  localparam int          STALL_LIMIT   = 1000;
  localparam int          RANDOM_PHASES = 12;
  localparam int          PHASE_BEATS   = 140;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic                          cfg_data = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic signed [VALUE_WIDTH-1:0] portfolio_value = '0;
  logic signed [VALUE_WIDTH-1:0] fund_value = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b1;
  logic signed [VALUE_WIDTH-1:0] money_down;
  logic signed [PCT_W-1:0]       percent_down;
  logic [VALUE_WIDTH-2:0]        max_money_down;
  logic [PCT_W-2:0]              max_percent_down;
  logic [COUNT_WIDTH-1:0]        down_run_length;
  logic [COUNT_WIDTH-1:0]        max_down_run_length;

  int pending_beats;
  int mismatches;

  // stimulus bookkeeping: selected mode and the highest value sent so far
  bit     idling_on = 1'b1;
  logic   mode_now = 1'b0;
  longint peak_seen = VALUE_MIN;
  int     stall_left = 0;
  int     idle_cycles = 0;

  running_drawdown_tracker_core #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_valid_i          (cfg_valid),
    .cfg_ready_o          (cfg_ready),
    .cfg_data_i           (cfg_data),
    .in_valid_i           (in_valid),
    .in_ready_o           (in_ready),
    .portfolio_value_i    (portfolio_value),
    .fund_value_i         (fund_value),
    .out_valid_o          (out_valid),
    .out_ready_i          (out_ready),
    .money_down_o         (money_down),
    .percent_down_o       (percent_down),
    .max_money_down_o     (max_money_down),
    .max_percent_down_o   (max_percent_down),
    .down_run_length_o    (down_run_length),
    .max_down_run_length_o(max_down_run_length)
  );

  drawdown_checker #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_check (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_valid_i          (cfg_valid),
    .cfg_ready_i          (cfg_ready),
    .cfg_data_i           (cfg_data),
    .in_valid_i           (in_valid),
    .in_ready_i           (in_ready),
    .portfolio_value_i    (portfolio_value),
    .fund_value_i         (fund_value),
    .out_valid_i          (out_valid),
    .out_ready_i          (out_ready),
    .money_down_i         (money_down),
    .percent_down_i       (percent_down),
    .max_money_down_i     (max_money_down),
    .max_percent_down_i   (max_percent_down),
    .down_run_length_i    (down_run_length),
    .max_down_run_length_i(max_down_run_length),
    .pending_beats_o      (pending_beats),
    .errors_o             (mismatches)
  );

  always #2 clk_i = ~clk_i;

  // receiver stalls in short bursts while idling is on
  always @(posedge clk_i) begin
    if (stall_left == 0 && idling_on && $urandom_range(0, 5) == 0)
      stall_left = $urandom_range(1, 3);
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // watchdog on cycles with no beat on any channel
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL running_drawdown_tracker_core");
      $finish;
    end
  end

  function automatic logic signed [VALUE_WIDTH-1:0] rand_word();
    return VALUE_WIDTH'({$urandom, $urandom});
  endfunction

  // one input beat, with an optional sender gap ahead of it
  task automatic send_value(input logic signed [VALUE_WIDTH-1:0] pv,
                            input logic signed [VALUE_WIDTH-1:0] fv);
    longint picked;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid        <= 1'b1;
    portfolio_value <= pv;
    fund_value      <= fv;
    do @(posedge clk_i); while (!in_ready);
    picked = mode_now ? fv : pv;
    if (picked > peak_seen) peak_seen = picked;
  endtask

  // mode writes happen only with the block drained
  task automatic write_mode(input logic mode);
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    mode_now = mode;
  endtask

  task automatic finish_phase();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending_beats != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int                            choice;
    int                            w;
    longint                        cand;
    logic [63:0]                   bits;
    logic signed [VALUE_WIDTH-1:0] pick;
    logic signed [VALUE_WIDTH-1:0] other;
    bit                            open_top;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // negative peaks: reset minimum, negative percent, low saturation, zero quotient
    send_value(VALUE_MIN, VALUE_MAX);
    send_value(NEG_PEAK, 48'h5555_5555_5555);
    send_value(NEG_PEAK - HALF_STEP, 48'hAAAA_AAAA_AAAA);
    send_value(VALUE_MIN + 1, 0);
    send_value(NEG_PEAK - 1, -1);
    finish_phase();

    // fund value selected: zero peak and money saturation
    write_mode(1'b1);
    send_value(VALUE_MIN, -HALF_STEP);
    send_value(VALUE_MAX, 0);
    send_value(1, -1);
    send_value(0, VALUE_MIN);
    finish_phase();

    // small positive peak: high saturation and a short run
    write_mode(1'b0);
    send_value(1, VALUE_MAX);
    send_value(0, rand_word());
    send_value(VALUE_MIN, 48'h5555_5555_5555);
    send_value(1, 48'hAAAA_AAAA_AAAA);
    repeat (3) send_value(0, rand_word());
    finish_phase();

    // random phases: mostly drawdowns under a slowly rising peak
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      idling_on <= (p < RANDOM_PHASES - 2);
      open_top = (p == RANDOM_PHASES - 1);
      write_mode((p < 2) ? p[0] : 1'($urandom_range(0, 1)));
      repeat (PHASE_BEATS) begin
        choice = $urandom_range(0, 99);
        if (choice < 75) begin
          w    = $urandom_range(0, VALUE_WIDTH);
          bits = {$urandom, $urandom} & ((64'd1 << w) - 64'd1);
          cand = peak_seen - longint'(bits);
          if (cand < VALUE_MIN) cand = VALUE_MIN;
        end else if (choice < 80) begin
          w = $clog2(peak_seen + 1);
          w = $urandom_range(w + 1, (w > 2) ? w - 2 : 1);
          if (w > VALUE_WIDTH - 1) w = VALUE_WIDTH - 1;
          bits = {$urandom, $urandom} & ((64'd1 << w) - 64'd1);
          if (bits == 0) bits = 64'd1;
          cand = peak_seen + longint'(bits);
          if (cand > VALUE_MAX) cand = VALUE_MAX;
        end else if (choice < 90) begin
          cand = peak_seen;
        end else begin
          case ($urandom_range(0, 5))
            0:       cand = VALUE_MIN;
            1:       cand = VALUE_MAX;
            2:       cand = 0;
            3:       cand = -1;
            4:       cand = 1;
            default: cand = rand_word();
          endcase
          // keep the peak sweep slow until the last phase
          if (!open_top && cand > peak_seen) cand = -cand;
        end
        pick  = VALUE_WIDTH'(cand);
        other = rand_word();
        if (mode_now) send_value(other, pick);
        else send_value(pick, other);
      end
      finish_phase();
    end

    if (mismatches == 0 && pending_beats == 0)
      $display("PASS running_drawdown_tracker_core");
    else
      $display("FAIL running_drawdown_tracker_core");
    $finish;
  end

endmodule
